// ===== sv/rv32_pkg.sv =====
// Shared types and constants of the RV32I instruction executor.
package rv32_pkg;

  // Byte memory size; must be a power of two and a multiple of four.
  localparam int unsigned MEM_BYTES = 131072;
  localparam int unsigned ADDR_W    = $clog2(MEM_BYTES);
  localparam int unsigned ROWS      = MEM_BYTES / 4;
  localparam int unsigned ROW_W     = ADDR_W - 2;

  localparam logic [31:0] HALT_RESET = 32'h00c6_8223;

  // Major opcodes.
  localparam logic [6:0] OPC_R      = 7'b0110011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_IMM    = 7'b0010011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;

  localparam logic [4:0] EXIT_REG = 5'd10;

  // Item operations.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Stop status codes.
  localparam logic [1:0] ST_RUN     = 2'd0;
  localparam logic [1:0] ST_HALT    = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_MEM
  } state_t;

  typedef struct packed {
    logic        op;
    logic [16:0] load_address;
    logic [7:0]  load_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  exit_value;
    logic [31:0] pc_now;
  } rsp_t;

endpackage

// ===== sv/rv32i_instruction_executor_core.sv =====
// Multi-cycle RV32I executor with banked byte memory and a memory-based register file.
//
// After reset the core sweeps its byte memory and register file to zero, one row of four
// bytes per cycle over MEM_BYTES/4 rows (32768 at the default size); req_stall stays high
// during that pass while cfg writes are taken. A write item is stored and answered as it is
// accepted. An execute item passes the fetch read of the four byte banks, the register file
// read, and execute and write back; a load adds the data memory read before write back.
// A halt is answered from the fetch state, a step on a stopped machine on acceptance; the
// response register lets a new item enter in the cycle its predecessor's result is taken.
module rv32i_instruction_executor_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  rv32_pkg::req_t      req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rv32_pkg::rsp_t      rsp,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);

  localparam int unsigned AW = rv32_pkg::ADDR_W;
  localparam int unsigned RW = rv32_pkg::ROW_W;

  rv32_pkg::state_t state, state_next;
  logic [31:0]   pc, pc_next;
  logic [1:0]    stop, stop_next;
  logic [31:0]   halt_word;
  logic [7:0]    exit_lo;
  logic [RW-1:0] clr_cnt;
  logic [31:0]   ir, ra, rb;
  logic [7:0]    q [4];
  logic [1:0]    lo;

  logic          out_ok, accept;
  logic          rsp_load;
  logic          mem_re, ld_we, st_we, clr_we;
  logic [AW-1:0] mem_base;
  logic [31:0]   la32;
  logic [31:0]   aw;
  logic          rf_re, rf_we;
  logic [31:0]   rf_wd;
  logic [31:0]   rf_a [32];
  logic [31:0]   rf_b [32];

  // Decode fields.
  logic [6:0]  opc;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic        alt;
  logic [31:0] imm_i, imm_s, imm_b, imm_j;
  logic [31:0] ea_l, ea_s;
  logic [31:0] res, nxt, ld_val;
  logic        take, illegal, wr;

  function automatic logic [31:0] alu(input logic [2:0] f, input logic sub,
                                      input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    begin
      case (f)
        3'd0:    r = sub ? a - b : a + b;
        3'd1:    r = a << b[4:0];
        3'd2:    r = {31'd0, $signed(a) < $signed(b)};
        3'd3:    r = {31'd0, a < b};
        3'd4:    r = a ^ b;
        3'd5:    r = sub ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
        3'd6:    r = a | b;
        default: r = a & b;
      endcase
      return r;
    end
  endfunction

  assign out_ok    = !rsp_valid || !rsp_stall;
  assign req_stall = !(state == rv32_pkg::S_IDLE && out_ok);
  assign accept    = req_valid && !req_stall;
  assign la32      = 32'(req.load_address);

  // Gather the four bytes from the banks, starting at the lane of the access.
  always_comb begin
    logic [1:0] idx;
    aw = '0;
    for (int i = 0; i < 4; i++) begin
      idx = lo + 2'(i);
      aw[8*i +: 8] = q[idx];
    end
  end

  // Instruction decode and execute.
  always_comb begin
    opc   = ir[6:0];
    rd    = ir[11:7];
    f3    = ir[14:12];
    alt   = ir[30];
    imm_i = {{20{ir[31]}}, ir[31:20]};
    imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
    imm_b = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
    imm_j = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
    ea_l  = ra + imm_i;
    ea_s  = ra + imm_s;
    res     = '0;
    nxt     = pc + 32'd4;
    take    = 1'b0;
    illegal = 1'b0;
    wr      = 1'b1;
    unique case (opc)
      rv32_pkg::OPC_R:     res = alu(f3, alt, ra, rb);
      rv32_pkg::OPC_IMM:   res = alu(f3, (f3 == 3'd5) && alt, ra, imm_i);
      rv32_pkg::OPC_LOAD: begin
        wr = 1'b0;
        illegal = (f3 == 3'd3) || (f3 == 3'd6) || (f3 == 3'd7);
      end
      rv32_pkg::OPC_STORE: begin
        wr = 1'b0;
        illegal = f3 > 3'd2;
      end
      rv32_pkg::OPC_BRANCH: begin
        wr = 1'b0;
        case (f3)
          3'd0:    take = ra == rb;
          3'd1:    take = ra != rb;
          3'd4:    take = $signed(ra) < $signed(rb);
          3'd5:    take = !($signed(ra) < $signed(rb));
          3'd6:    take = ra < rb;
          3'd7:    take = ra >= rb;
          default: illegal = 1'b1;
        endcase
        if (take) begin
          nxt = pc + imm_b;
        end
      end
      rv32_pkg::OPC_JALR: begin
        illegal = f3 != 3'd0;
        res = pc + 32'd4;
        nxt = ea_l & 32'hffff_fffe;
      end
      rv32_pkg::OPC_JAL: begin
        res = pc + 32'd4;
        nxt = pc + imm_j;
      end
      rv32_pkg::OPC_LUI:   res = {ir[31:12], 12'd0};
      rv32_pkg::OPC_AUIPC: res = pc + {ir[31:12], 12'd0};
      default:             illegal = 1'b1;
    endcase
  end

  // Load data extension.
  always_comb begin
    case (f3)
      3'd0:    ld_val = {{24{aw[7]}}, aw[7:0]};
      3'd1:    ld_val = {{16{aw[15]}}, aw[15:0]};
      3'd4:    ld_val = {24'd0, aw[7:0]};
      3'd5:    ld_val = {16'd0, aw[15:0]};
      default: ld_val = aw;
    endcase
  end

  // Sequencer: next state and control.
  always_comb begin
    state_next = state;
    pc_next    = pc;
    stop_next  = stop;
    rsp_load   = 1'b0;
    mem_re     = 1'b0;
    ld_we      = 1'b0;
    st_we      = 1'b0;
    clr_we     = 1'b0;
    rf_re      = 1'b0;
    rf_we      = 1'b0;
    rf_wd      = res;
    mem_base   = '0;
    unique case (state)
      rv32_pkg::S_CLEAR: begin
        clr_we = 1'b1;
        if (clr_cnt == RW'(rv32_pkg::ROWS - 1)) begin
          state_next = rv32_pkg::S_IDLE;
        end
      end
      rv32_pkg::S_IDLE: begin
        mem_base = (req.op == rv32_pkg::OP_STEP) ? pc[AW-1:0] : la32[AW-1:0];
        if (accept) begin
          if (req.op == rv32_pkg::OP_WRITE) begin
            ld_we    = 1'b1;
            rsp_load = 1'b1;
          end else if (stop != rv32_pkg::ST_RUN) begin
            rsp_load = 1'b1;
          end else begin
            mem_re     = 1'b1;
            state_next = rv32_pkg::S_FETCH;
          end
        end
      end
      rv32_pkg::S_FETCH: begin
        if (aw == halt_word) begin
          if (out_ok) begin
            stop_next  = rv32_pkg::ST_HALT;
            rsp_load   = 1'b1;
            state_next = rv32_pkg::S_IDLE;
          end
        end else begin
          rf_re      = 1'b1;
          state_next = rv32_pkg::S_EXEC;
        end
      end
      rv32_pkg::S_EXEC: begin
        mem_base = (opc == rv32_pkg::OPC_STORE) ? ea_s[AW-1:0] : ea_l[AW-1:0];
        if (illegal) begin
          if (out_ok) begin
            stop_next  = rv32_pkg::ST_ILLEGAL;
            rsp_load   = 1'b1;
            state_next = rv32_pkg::S_IDLE;
          end
        end else if (opc == rv32_pkg::OPC_LOAD) begin
          mem_re     = 1'b1;
          state_next = rv32_pkg::S_MEM;
        end else if (out_ok) begin
          st_we      = opc == rv32_pkg::OPC_STORE;
          rf_we      = wr;
          pc_next    = nxt;
          rsp_load   = 1'b1;
          state_next = rv32_pkg::S_IDLE;
        end
      end
      rv32_pkg::S_MEM: begin
        if (out_ok) begin
          rf_we      = 1'b1;
          rf_wd      = ld_val;
          pc_next    = pc + 32'd4;
          rsp_load   = 1'b1;
          state_next = rv32_pkg::S_IDLE;
        end
      end
      default: state_next = rv32_pkg::S_IDLE;
    endcase
  end

  // Four byte-wide banks; bank k holds the bytes whose address is k modulo four.
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]    bank_mem [rv32_pkg::ROWS];
    logic [1:0]    off;
    logic [AW-1:0] full;
    logic [RW-1:0] row;
    logic          en_st, we;
    logic [7:0]    wd;

    always_comb begin
      off   = 2'(k) - mem_base[1:0];
      full  = mem_base + AW'(off);
      row   = clr_we ? clr_cnt : full[AW-1:2];
      case (f3)
        3'd0:    en_st = off == 2'd0;
        3'd1:    en_st = !off[1];
        default: en_st = 1'b1;
      endcase
      we = clr_we || (ld_we && off == 2'd0) || (st_we && en_st);
      if (clr_we) begin
        wd = '0;
      end else if (ld_we) begin
        wd = req.load_byte;
      end else begin
        wd = rb[8*off +: 8];
      end
    end

    always_ff @(posedge clk) begin
      if (we) begin
        bank_mem[row] <= wd;
      end
      if (mem_re) begin
        q[k] <= bank_mem[row];
      end
    end
  end

  // Register file: two copies give two read ports.
  always_ff @(posedge clk) begin
    if (clr_we) begin
      rf_a[clr_cnt[4:0]] <= '0;
      rf_b[clr_cnt[4:0]] <= '0;
    end else if (rf_we && rd != 5'd0) begin
      rf_a[rd] <= rf_wd;
      rf_b[rd] <= rf_wd;
    end
    if (rf_re) begin
      ra <= rf_a[aw[19:15]];
      rb <= rf_b[aw[24:20]];
      ir <= aw;
    end
    if (mem_re) begin
      lo <= mem_base[1:0];
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status     <= stop_next;
      rsp.exit_value <= (stop_next == rv32_pkg::ST_HALT) ? exit_lo : 8'd0;
      rsp.pc_now     <= pc_next;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rv32_pkg::S_CLEAR;
      pc        <= '0;
      stop      <= rv32_pkg::ST_RUN;
      halt_word <= rv32_pkg::HALT_RESET;
      exit_lo   <= '0;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      stop  <= stop_next;
      if (cfg_we) begin
        halt_word <= cfg_wdata;
      end
      if (rf_we && rd == rv32_pkg::EXIT_REG) begin
        exit_lo <= rf_wd[7:0];
      end
      if (clr_we) begin
        clr_cnt <= clr_cnt + RW'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== dv/rv32_f3_pkg.sv =====
// Minor opcode (funct3) codes of RV32I shared by the executor testbench files.
`timescale 1ns / 100ps
package rv32_f3_pkg;

  // ALU operations for register and immediate formats.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Load widths.
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  // Store widths.
  localparam logic [2:0] F3_SB = 3'd0;
  localparam logic [2:0] F3_SH = 3'd1;
  localparam logic [2:0] F3_SW = 3'd2;

  // Branch conditions.
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_JALR = 3'd0;

endpackage

// ===== dv/rv32_exec_checker.sv =====
// Checker that mirrors the executor's state, predicts each result and compares it.
`timescale 1ns / 100ps
module rv32_exec_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  rv32_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  rv32_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata,
  output int             errors,
  output int             pending
);
  import rv32_pkg::*;
  import rv32_f3_pkg::*;

  // Mirrored machine state.
  logic [7:0]  mem [MEM_BYTES];
  logic [31:0] regs [32];
  logic [31:0] pc;
  logic [1:0]  stop;
  logic [31:0] halt_word;
  rsp_t        expected_rsp [$];

  function automatic logic [ADDR_W-1:0] wrap(input logic [31:0] base, input int off);
    logic [31:0] a;
    a = base + off;
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic [31:0] mem_rd(input logic [31:0] addr, input int n);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v |= 32'(mem[wrap(addr, i)]) << (8 * i);
    return v;
  endfunction

  function automatic logic [31:0] alu(input logic [2:0] f3, input bit alt,
                                      input logic [31:0] a, input logic [31:0] b);
    case (f3)
      F3_ADD:  return alt ? a - b : a + b;
      F3_SLL:  return a << b[4:0];
      F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
      F3_XOR:  return a ^ b;
      F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  // Executes one instruction word; returns 0 on an illegal word without touching state.
  function automatic bit execute(input logic [31:0] w);
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, ad, res, nxt, v;
    bit          wr, take;
    f3 = w[14:12];
    rd = w[11:7];
    a = regs[w[19:15]];
    b = regs[w[24:20]];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    nxt = pc + 32'd4;
    res = '0;
    wr = 1;
    take = 0;
    case (w[6:0])
      OPC_R:   res = alu(f3, w[30], a, b);
      OPC_IMM: res = alu(f3, (f3 == F3_SR) && w[30], a, imm_i);
      OPC_LOAD: begin
        ad = a + imm_i;
        v = mem_rd(ad, 4);
        case (f3)
          F3_LB:   res = {{24{v[7]}}, v[7:0]};
          F3_LH:   res = {{16{v[15]}}, v[15:0]};
          F3_LW:   res = v;
          F3_LBU:  res = {24'd0, v[7:0]};
          F3_LHU:  res = {16'd0, v[15:0]};
          default: return 0;
        endcase
      end
      OPC_STORE: begin
        if (f3 > F3_SW) return 0;
        ad = a + imm_s;
        for (int i = 0; i < (1 << f3); i++) mem[wrap(ad, i)] = b[8*i +: 8];
        wr = 0;
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  take = (a == b);
          F3_BNE:  take = (a != b);
          F3_BLT:  take = ($signed(a) < $signed(b));
          F3_BGE:  take = !($signed(a) < $signed(b));
          F3_BLTU: take = (a < b);
          F3_BGEU: take = (a >= b);
          default: return 0;
        endcase
        if (take) nxt = pc + imm_b;
        wr = 0;
      end
      OPC_JALR: begin
        if (f3 != F3_JALR) return 0;
        res = pc + 32'd4;
        nxt = (a + imm_i) & 32'hffff_fffe;
      end
      OPC_JAL: begin
        res = pc + 32'd4;
        nxt = pc + imm_j;
      end
      OPC_LUI:   res = {w[31:12], 12'h000};
      OPC_AUIPC: res = pc + {w[31:12], 12'h000};
      default:   return 0;
    endcase
    if (wr && rd != 5'd0) regs[rd] = res;
    regs[0] = '0;
    pc = nxt;
    return 1;
  endfunction

  // Applies one accepted item to the mirror and returns the result it should give.
  function automatic rsp_t predict_result(input req_t r);
    rsp_t        e;
    logic [31:0] w;
    if (r.op == OP_WRITE) begin
      mem[r.load_address] = r.load_byte;
    end else if (stop == ST_RUN) begin
      w = mem_rd(pc, 4);
      if (w == halt_word) stop = ST_HALT;
      else if (!execute(w)) stop = ST_ILLEGAL;
    end
    e.status = stop;
    e.exit_value = (stop == ST_HALT) ? regs[EXIT_REG][7:0] : 8'd0;
    e.pc_now = pc;
    return e;
  endfunction

  // Results are compared before new items are predicted, all on the sampled edge.
  always @(posedge clk) begin
    rsp_t exp_r;
    if (rst) begin
      for (int i = 0; i < MEM_BYTES; i++) mem[i] = '0;
      for (int i = 0; i < 32; i++) regs[i] = '0;
      pc = '0;
      stop = ST_RUN;
      halt_word = HALT_RESET;
      expected_rsp.delete();
      errors = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          exp_r = expected_rsp.pop_front();
          if (rsp.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, rsp.status);
            errors++;
          end
          if (rsp.exit_value !== exp_r.exit_value) begin
            $error("exit_value expected %0d actual %0d", exp_r.exit_value, rsp.exit_value);
            errors++;
          end
          if (rsp.pc_now !== exp_r.pc_now) begin
            $error("pc_now expected %h actual %h", exp_r.pc_now, rsp.pc_now);
            errors++;
          end
        end
      end
      if (cfg_we) halt_word = cfg_wdata;
      if (req_valid && !req_stall) expected_rsp.push_back(predict_result(req));
    end
    pending = expected_rsp.size();
  end

endmodule

// ===== dv/tb.sv =====
// Top of the executor testbench: clock, reset, program stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb;
  import rv32_pkg::*;
  import rv32_f3_pkg::*;

  localparam int          WATCHDOG = 200000;
  localparam logic [31:0] HALT_END = 32'h0000_0073;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          errors;
  int          pending;

  int          idle_pct;
  int          stall_pct;
  int          hold_reqs;
  int          hold_seen;
  int          hold_left;
  int          items_sent;
  int          results_seen;
  int          steps_sent;
  int          batches;
  int          halt_writes;
  int          quiet_cycles;
  logic [31:0] last_pc;
  logic [31:0] code [$];

  rv32i_instruction_executor_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rv32_exec_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: random stalls plus long hold-offs requested by the stimulus.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      rsp_stall <= 1'b1;
      hold_seen <= hold_reqs;
      hold_left <= 300;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result tracking; the last pc tells where the next code goes.
  always @(posedge clk) begin
    if (rst) begin
      results_seen <= 0;
      last_pc <= '0;
    end else if (rsp_valid && !rsp_stall) begin
      results_seen <= results_seen + 1;
      last_pc <= rsp.pc_now;
    end
  end

  // Watchdog over cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send(input req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_write(input logic [31:0] addr, input logic [7:0] b);
    req_t r;
    r.op = OP_WRITE;
    r.load_address = addr[ADDR_W-1:0];
    r.load_byte = b;
    send(r);
  endtask

  // Step items carry random don't-care fields.
  task automatic send_step();
    req_t r;
    r = req_t'($urandom);
    r.op = OP_STEP;
    send(r);
    steps_sent++;
  endtask

  task automatic send_noise();
    logic [31:0] v;
    v = $urandom;
    send_write(v, v[31:24]);
  endtask

  // Waits until every expected result has come back.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (results_seen != items_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_halt(input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    halt_writes++;
  endtask

  // Places the queued code at the current pc and executes it word by word.
  task automatic run_code();
    logic [31:0] base;
    drain();
    base = last_pc;
    foreach (code[j])
      for (int i = 0; i < 4; i++) send_write(base + 4 * j + i, code[j][8*i +: 8]);
    foreach (code[j]) send_step();
    batches++;
  endtask

  // A random legal instruction word; funct3 is repaired where a code is unused.
  function automatic logic [31:0] rand_insn(input bit control);
    logic [31:0] w;
    logic [2:0]  ld_f3 [5] = '{F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU};
    logic [2:0]  br_f3 [6] = '{F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU};
    w = $urandom;
    if (control) begin
      case ($urandom_range(0, 2))
        0: begin
          w[6:0] = OPC_BRANCH;
          w[14:12] = br_f3[$urandom_range(0, 5)];
        end
        1: w[6:0] = OPC_JAL;
        default: begin
          w[6:0] = OPC_JALR;
          w[14:12] = F3_JALR;
        end
      endcase
    end else begin
      case ($urandom_range(0, 6))
        0, 1: w[6:0] = OPC_R;
        2, 3: w[6:0] = OPC_IMM;
        4: begin
          w[6:0] = OPC_LOAD;
          w[14:12] = ld_f3[$urandom_range(0, 4)];
        end
        5: begin
          w[6:0] = OPC_STORE;
          w[14:12] = 3'($urandom_range(F3_SB, F3_SW));
        end
        default: w[6:0] = $urandom_range(0, 1) ? OPC_LUI : OPC_AUIPC;
      endcase
    end
    return w;
  endfunction

  initial begin
    logic [31:0] hv;
    int          k;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_reqs = 0;
    items_sent = 0;
    steps_sent = 0;
    batches = 0;
    halt_writes = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: memory ends, a halfword store and load that wrap past the top byte.
    send_write(MEM_BYTES - 1, 8'hff);
    send_write(32'd0, 8'h00);
    code = '{{20'hfffff, 5'd10, OPC_LUI},
             {12'hfff, 5'd0, F3_ADD, 5'd3, OPC_IMM},
             {7'h7f, 5'd3, 5'd0, F3_SH, 5'h1f, OPC_STORE},
             {12'hfff, 5'd0, F3_LH, 5'd4, OPC_LOAD}};
    run_code();

    // Random code in phases, each with its own idling mix and halt word.
    while (items_sent < 830) begin
      if (batches % 8 == 1) begin
        drain();
        case ((batches / 8) % 4)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 56; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 56; end
          default: begin idle_pct = 26; stall_pct = 26; end
        endcase
        hv = $urandom;
        case ((batches / 8) % 4)
          0: hv = '0;
          1: hv = '1;
          2: hv[6:0] = 7'h7f;
          default: hv = HALT_RESET;
        endcase
        set_halt(hv);
      end
      if (batches == 5 || batches == 20) begin
        hold_reqs++;
        repeat (30) send_noise();
      end
      repeat ($urandom_range(0, 2)) send_noise();
      code.delete();
      k = $urandom_range(1, 4);
      repeat (k) code.push_back(rand_insn(1'b0));
      if ($urandom_range(0, 1)) code.push_back(rand_insn(1'b1));
      run_code();
    end

    // Closing: set x10, halt, then steps and a write while stopped.
    drain();
    set_halt(HALT_END);
    code = '{{12'h05a, 5'd0, F3_ADD, 5'd10, OPC_IMM}, HALT_END};
    run_code();
    send_step();
    send_noise();
    send_step();
    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d items, %0d of them instruction steps, in %0d code batches.",
             items_sent, steps_sent, batches);
    $display("Four idling mixes, two long receiver hold-offs, %0d halt word settings.",
             halt_writes);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
